FILE: rtl/salcp_pkg.sv
// Shared constants and the sequencer state type for the suffix array / LCP builder.
// No dependencies; the builder RTL and the bench import this package.
`default_nettype none

package salcp_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int NBUCKETS    = 256;
    localparam int CHAR_W      = 8;
    localparam int RANK_W      = 8;
    localparam int POS_W       = 6;
    localparam int LCP_W       = 7;
    localparam int SWEEP_W     = $clog2(NBUCKETS) + 1;

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_INIT_W,
        S_CLR,
        S_CNT_R,
        S_CNT_B,
        S_CNT_W,
        S_PFX,
        S_PL_O,
        S_PL_R,
        S_PL_B,
        S_PL_W,
        S_CPY_R,
        S_CPY_W,
        S_RK_O,
        S_RK_A,
        S_RK_K,
        S_RK_W,
        S_RC_R,
        S_RC_W,
        S_PM_O,
        S_PM_W,
        S_PH_S,
        S_PH_P,
        S_CMP_A,
        S_CMP_B,
        S_CMP_C,
        S_OUT_O,
        S_OUT_P,
        S_OUT_E
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/salcp_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Used for every array of the suffix array / LCP builder; no package dependency.
`default_nettype none

module salcp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/suffix_array_lcp_builder_unit.sv
// Suffix array builder (prefix doubling, counting sorts) with phi-based LCP computation.
// While idle, a byte is loaded whenever start is high; the byte with last_char set starts the build.
// Each doubling round runs two counting passes, each sweeping the 256-entry bucket memory
// to clear it and to form prefix sums; at most ceil(log2(n))+1 rounds.
// The LCP phase follows, then the results, one at a time, n in all.
// busy is high from the final byte until the last result; rst_n (async) returns to loading.
`default_nettype none

module suffix_array_lcp_builder_unit #(
    parameter int MAX_LEN = salcp_pkg::MAX_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [salcp_pkg::CHAR_W-1:0]  char_in,
    input  wire logic                          last_char,
    output logic                               result_strobe,
    output logic      [salcp_pkg::POS_W-1:0]   sorted_pos,
    output logic      [salcp_pkg::POS_W-1:0]   suffix_start,
    output logic      [salcp_pkg::LCP_W-1:0]   common_prefix,
    output logic                               last_result
);

    import salcp_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int KW = LW + 1;
    localparam int SW = KW + 1;
    localparam int BA = $clog2(NBUCKETS);

    state_t state_reg, state_next;

    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      n_reg, n_next;
    logic [LW-1:0]      i_reg, i_next;
    logic [LW-1:0]      tail_reg, tail_next;
    logic [LW-1:0]      l_reg, l_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      off_reg, off_next;
    logic [KW-1:0]      sum_reg, sum_next;
    logic [SWEEP_W-1:0] cnt_reg, cnt_next;
    logic               pass_reg, pass_next;
    logic [RANK_W-1:0]  r_reg, r_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      prev_ord_reg, prev_ord_next;
    logic [AW-1:0]      first_reg, first_next;
    logic [BA-1:0]      bkt_reg, bkt_next;
    logic [RANK_W-1:0]  cur_r_reg, cur_r_next;
    logic               cur_ok_reg, cur_ok_next;
    logic [RANK_W-1:0]  prev_r_reg, prev_r_next;
    logic               prev_ok_reg, prev_ok_next;
    logic [RANK_W-1:0]  prev_rk_reg, prev_rk_next;
    logic [CHAR_W-1:0]  ta_reg, ta_next;

    logic               strobe_reg, strobe_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [LCP_W-1:0]   lcp_reg, lcp_next;
    logic               last_reg, last_next;

    // Memory ports.
    logic              tx_we;
    logic [AW-1:0]     tx_waddr, tx_raddr;
    logic [CHAR_W-1:0] tx_wdata, tx_rd;
    logic              ra_we;
    logic [AW-1:0]     ra_waddr, ra_raddr;
    logic [RANK_W-1:0] ra_wdata, ra_rd;
    logic              rb_we;
    logic [AW-1:0]     rb_waddr, rb_raddr;
    logic [RANK_W-1:0] rb_wdata, rb_rd;
    logic              oa_we;
    logic [AW-1:0]     oa_waddr, oa_raddr;
    logic [AW-1:0]     oa_wdata, oa_rd;
    logic              ob_we;
    logic [AW-1:0]     ob_waddr, ob_raddr;
    logic [AW-1:0]     ob_wdata, ob_rd;
    logic              bk_we;
    logic [BA-1:0]     bk_waddr, bk_raddr;
    logic [KW-1:0]     bk_wdata, bk_rd;
    logic              pm_we;
    logic [AW-1:0]     pm_waddr, pm_raddr;
    logic [AW-1:0]     pm_wdata, pm_rd;
    logic              pp_we;
    logic [AW-1:0]     pp_waddr, pp_raddr;
    logic [LW-1:0]     pp_wdata, pp_rd;

    logic [SW-1:0] n_ext, sum_il, sum_pl, sum_pk, sum_ak;
    logic [LW-1:0] i_inc;
    logic          i_done;
    logic          same;
    logic [RANK_W-1:0] r_new;

    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_text (
        .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
        .raddr(tx_raddr), .rdata(tx_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(RANK_W)) u_rank_a (
        .clk(clk), .we(ra_we), .waddr(ra_waddr), .wdata(ra_wdata),
        .raddr(ra_raddr), .rdata(ra_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(RANK_W)) u_rank_b (
        .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
        .raddr(rb_raddr), .rdata(rb_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_order_a (
        .clk(clk), .we(oa_we), .waddr(oa_waddr), .wdata(oa_wdata),
        .raddr(oa_raddr), .rdata(oa_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_order_b (
        .clk(clk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
        .raddr(ob_raddr), .rdata(ob_rd));
    salcp_ram #(.DEPTH(NBUCKETS), .WIDTH(KW)) u_bucket (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
        .raddr(bk_raddr), .rdata(bk_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_prev_map (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rd));
    salcp_ram #(.DEPTH(MAX_LEN), .WIDTH(LW)) u_plcp (
        .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
        .raddr(pp_raddr), .rdata(pp_rd));

    assign n_ext  = SW'(n_reg);
    assign sum_il = SW'(i_reg) + SW'(l_reg);
    assign sum_pl = SW'(p_reg) + SW'(l_reg);
    assign sum_pk = SW'(oa_rd) + SW'(off_reg);
    assign sum_ak = SW'(a_reg) + SW'(k_reg);
    assign i_inc  = i_reg + LW'(1);
    assign i_done = (i_inc == n_reg);

    // Two neighbors share a rank only if both halves match and both second halves exist.
    assign same  = (i_reg != '0) && (cur_r_reg == prev_r_reg) && cur_ok_reg && prev_ok_reg
                   && (ra_rd == prev_rk_reg);
    assign r_new = (i_reg == '0) ? '0 : (same ? r_reg : r_reg + RANK_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            len_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        tail_reg     <= tail_next;
        l_reg        <= l_next;
        k_reg        <= k_next;
        off_reg      <= off_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        pass_reg     <= pass_next;
        r_reg        <= r_next;
        p_reg        <= p_next;
        a_reg        <= a_next;
        prev_ord_reg <= prev_ord_next;
        first_reg    <= first_next;
        bkt_reg      <= bkt_next;
        cur_r_reg    <= cur_r_next;
        cur_ok_reg   <= cur_ok_next;
        prev_r_reg   <= prev_r_next;
        prev_ok_reg  <= prev_ok_next;
        prev_rk_reg  <= prev_rk_next;
        ta_reg       <= ta_next;
        pos_reg      <= pos_next;
        start_reg    <= start_next;
        lcp_reg      <= lcp_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        tail_next     = tail_reg;
        l_next        = l_reg;
        k_next        = k_reg;
        off_next      = off_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        r_next        = r_reg;
        p_next        = p_reg;
        a_next        = a_reg;
        prev_ord_next = prev_ord_reg;
        first_next    = first_reg;
        bkt_next      = bkt_reg;
        cur_r_next    = cur_r_reg;
        cur_ok_next   = cur_ok_reg;
        prev_r_next   = prev_r_reg;
        prev_ok_next  = prev_ok_reg;
        prev_rk_next  = prev_rk_reg;
        ta_next       = ta_reg;
        strobe_next   = 1'b0;
        pos_next      = pos_reg;
        start_next    = start_reg;
        lcp_next      = lcp_reg;
        last_next     = last_reg;

        tx_we = 1'b0; tx_waddr = len_reg[AW-1:0]; tx_wdata = char_in; tx_raddr = i_reg[AW-1:0];
        ra_we = 1'b0; ra_waddr = i_reg[AW-1:0];   ra_wdata = tx_rd;   ra_raddr = i_reg[AW-1:0];
        rb_we = 1'b0; rb_waddr = a_reg;           rb_wdata = r_new;   rb_raddr = i_reg[AW-1:0];
        oa_we = 1'b0; oa_waddr = i_reg[AW-1:0];   oa_wdata = ob_rd;   oa_raddr = i_reg[AW-1:0];
        ob_we = 1'b0; ob_waddr = tail_reg[AW-1:0]; ob_wdata = oa_rd;  ob_raddr = i_reg[AW-1:0];
        bk_we = 1'b0; bk_waddr = bkt_reg;         bk_wdata = '0;      bk_raddr = cnt_reg[BA-1:0];
        pm_we = 1'b0; pm_waddr = oa_rd;           pm_wdata = prev_ord_reg;
        pm_raddr = i_reg[AW-1:0];
        pp_we = 1'b0; pp_waddr = i_reg[AW-1:0];   pp_wdata = l_reg;   pp_raddr = oa_rd;

        busy = (state_reg != S_LOAD);

        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    if (len_reg < LW'(MAX_LEN))
                    begin
                        tx_we    = 1'b1;
                        len_next = len_reg + LW'(1);
                    end
                    if (last_char)
                    begin
                        n_next     = (len_reg < LW'(MAX_LEN)) ? len_reg + LW'(1) : len_reg;
                        len_next   = '0;
                        i_next     = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                oa_we      = 1'b1;
                oa_wdata   = i_reg[AW-1:0];
                state_next = S_INIT_W;
            end
            S_INIT_W:
            begin
                ra_we = 1'b1;
                if (i_done)
                begin
                    k_next     = KW'(1);
                    off_next   = KW'(1);
                    pass_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_INIT;
                end
            end
            S_CLR:
            begin
                bk_we    = 1'b1;
                bk_waddr = cnt_reg[BA-1:0];
                cnt_next = cnt_reg + SWEEP_W'(1);
                if (cnt_reg == SWEEP_W'(NBUCKETS - 1))
                begin
                    cnt_next = '0;
                    sum_next = off_reg;
                    i_next   = off_reg[LW-1:0];
                    if (off_reg < KW'(n_reg))
                    begin
                        state_next = S_CNT_R;
                    end
                    else
                    begin
                        state_next = S_PFX;
                    end
                end
            end
            S_CNT_R:
            begin
                state_next = S_CNT_B;
            end
            S_CNT_B:
            begin
                bk_raddr   = ra_rd;
                bkt_next   = ra_rd;
                state_next = S_CNT_W;
            end
            S_CNT_W:
            begin
                bk_we    = 1'b1;
                bk_wdata = bk_rd + KW'(1);
                if (i_done)
                begin
                    cnt_next   = '0;
                    state_next = S_PFX;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_CNT_R;
                end
            end
            S_PFX:
            begin
                // Read data of the previous cycle becomes the running sum's next addend.
                if (cnt_reg != '0)
                begin
                    bk_we    = 1'b1;
                    bk_waddr = BA'(cnt_reg - SWEEP_W'(1));
                    bk_wdata = sum_reg;
                    sum_next = sum_reg + bk_rd;
                end
                if (cnt_reg == SWEEP_W'(NBUCKETS))
                begin
                    i_next     = '0;
                    tail_next  = '0;
                    state_next = S_PL_O;
                end
                else
                begin
                    cnt_next = cnt_reg + SWEEP_W'(1);
                end
            end
            S_PL_O:
            begin
                state_next = S_PL_R;
            end
            S_PL_R:
            begin
                p_next = oa_rd;
                if (sum_pk < n_ext)
                begin
                    ra_raddr   = sum_pk[AW-1:0];
                    state_next = S_PL_B;
                end
                else
                begin
                    ob_we     = (tail_reg < n_reg);
                    tail_next = tail_reg + LW'(1);
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = S_CPY_R;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_PL_O;
                    end
                end
            end
            S_PL_B:
            begin
                bk_raddr   = ra_rd;
                bkt_next   = ra_rd;
                state_next = S_PL_W;
            end
            S_PL_W:
            begin
                bk_we    = 1'b1;
                bk_wdata = bk_rd + KW'(1);
                ob_we    = (bk_rd < KW'(n_reg));
                ob_waddr = bk_rd[AW-1:0];
                ob_wdata = p_reg;
                if (i_done)
                begin
                    i_next     = '0;
                    state_next = S_CPY_R;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_PL_O;
                end
            end
            S_CPY_R:
            begin
                state_next = S_CPY_W;
            end
            S_CPY_W:
            begin
                oa_we = 1'b1;
                if (i_done)
                begin
                    i_next = '0;
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        off_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        r_next     = '0;
                        state_next = S_RK_O;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_CPY_R;
                end
            end
            S_RK_O:
            begin
                state_next = S_RK_A;
            end
            S_RK_A:
            begin
                a_next     = oa_rd;
                ra_raddr   = oa_rd;
                state_next = S_RK_K;
            end
            S_RK_K:
            begin
                cur_r_next  = ra_rd;
                cur_ok_next = (sum_ak < n_ext);
                ra_raddr    = sum_ak[AW-1:0];
                state_next  = S_RK_W;
            end
            S_RK_W:
            begin
                rb_we        = 1'b1;
                r_next       = r_new;
                prev_r_next  = cur_r_reg;
                prev_ok_next = cur_ok_reg;
                prev_rk_next = ra_rd;
                if (i_done)
                begin
                    i_next     = '0;
                    state_next = S_RC_R;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_RK_O;
                end
            end
            S_RC_R:
            begin
                state_next = S_RC_W;
            end
            S_RC_W:
            begin
                ra_we    = 1'b1;
                ra_wdata = rb_rd;
                if (i_done)
                begin
                    i_next = '0;
                    if ((r_reg == RANK_W'(n_reg - LW'(1))) || (k_reg >= KW'(n_reg)))
                    begin
                        state_next = S_PM_O;
                    end
                    else
                    begin
                        k_next     = k_reg << 1;
                        off_next   = k_reg << 1;
                        pass_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = S_CLR;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_RC_R;
                end
            end
            S_PM_O:
            begin
                state_next = S_PM_W;
            end
            S_PM_W:
            begin
                if (i_reg != '0)
                begin
                    pm_we = 1'b1;
                end
                else
                begin
                    first_next = oa_rd;
                end
                prev_ord_next = oa_rd;
                if (i_done)
                begin
                    i_next     = '0;
                    l_next     = '0;
                    state_next = S_PH_S;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_PM_O;
                end
            end
            S_PH_S:
            begin
                if (i_reg[AW-1:0] == first_reg)
                begin
                    pp_we    = 1'b1;
                    pp_wdata = '0;
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = S_OUT_O;
                    end
                    else
                    begin
                        i_next = i_inc;
                    end
                end
                else
                begin
                    state_next = S_PH_P;
                end
            end
            S_PH_P:
            begin
                p_next     = pm_rd;
                state_next = S_CMP_A;
            end
            S_CMP_A:
            begin
                if ((sum_il < n_ext) && (sum_pl < n_ext))
                begin
                    tx_raddr   = sum_il[AW-1:0];
                    state_next = S_CMP_B;
                end
                else
                begin
                    pp_we  = 1'b1;
                    l_next = (l_reg != '0) ? l_reg - LW'(1) : '0;
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = S_OUT_O;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_PH_S;
                    end
                end
            end
            S_CMP_B:
            begin
                ta_next    = tx_rd;
                tx_raddr   = sum_pl[AW-1:0];
                state_next = S_CMP_C;
            end
            S_CMP_C:
            begin
                if (tx_rd == ta_reg)
                begin
                    l_next     = l_reg + LW'(1);
                    state_next = S_CMP_A;
                end
                else
                begin
                    pp_we  = 1'b1;
                    l_next = (l_reg != '0) ? l_reg - LW'(1) : '0;
                    if (i_done)
                    begin
                        i_next     = '0;
                        state_next = S_OUT_O;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_PH_S;
                    end
                end
            end
            S_OUT_O:
            begin
                state_next = S_OUT_P;
            end
            S_OUT_P:
            begin
                a_next     = oa_rd;
                state_next = S_OUT_E;
            end
            S_OUT_E:
            begin
                pp_raddr    = a_reg;
                strobe_next = 1'b1;
                pos_next    = POS_W'(i_reg);
                start_next  = POS_W'(a_reg);
                last_next   = i_done;
                if (i_done)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_OUT_O;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // The LCP read is issued in S_OUT_P; its data arrives during S_OUT_E.
        if (state_reg == S_OUT_P)
        begin
            pp_raddr = oa_rd;
        end
        if (state_reg == S_OUT_E)
        begin
            lcp_next = LCP_W'(pp_rd);
        end
    end

    assign result_strobe = strobe_reg;
    assign sorted_pos    = pos_reg;
    assign suffix_start  = start_reg;
    assign common_prefix = lcp_reg;
    assign last_result   = last_reg;

endmodule

`default_nettype wire

FILE: rtl/salcp_checker.sv
// Port-level checker for the suffix array / LCP builder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module salcp_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_char,
    input wire logic result_strobe,
    input wire logic last_result
);

    // A result that is not the final one leaves the block still building.
    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |-> busy)
        else $error("non-final result while idle");

    // After the final result of a transaction no further result follows at once.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_result |=> !result_strobe)
        else $error("result after the final one");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_char |=> !busy && !result_strobe)
        else $error("loading a byte started a build");

    a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_char |=> busy)
        else $error("final byte did not start a build");

endmodule

bind suffix_array_lcp_builder_unit salcp_checker u_salcp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .last_char(last_char),
    .result_strobe(result_strobe),
    .last_result(last_result)
);

`default_nettype wire

FILE: bench/suffix_array_lcp_builder_unit_test.sv
// Self-checking bench for suffix_array_lcp_builder_unit: loads byte strings, predicts the
// suffix array and LCP array in the bench, and compares every emitted result.
// Depends on salcp_pkg and the builder RTL.
`default_nettype none

module suffix_array_lcp_builder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import salcp_pkg::*;

    localparam int TEXT_MAX = 64;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } byte_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] start_idx;
        logic [LCP_W-1:0] lcp;
        logic             fin;
    } sa_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [CHAR_W-1:0] char_in = '0;
    logic last_char = 1'b0;
    wire busy, result_strobe, last_result;
    wire [POS_W-1:0] sorted_pos, suffix_start;
    wire [LCP_W-1:0] common_prefix;

    suffix_array_lcp_builder_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .char_in(char_in), .last_char(last_char),
        .result_strobe(result_strobe), .sorted_pos(sorted_pos),
        .suffix_start(suffix_start), .common_prefix(common_prefix),
        .last_result(last_result)
    );

    always #5 clk = ~clk;

    byte_item_t pending_bytes[$];
    sa_entry_t  expected_entries[$];
    int errors = 0;
    int entries_seen = 0;
    int strings_built = 0;
    int bytes_sent = 0;
    int cycles = 0;
    bit stimulus_done = 0;

    // Predictor state: the string collected so far.
    byte unsigned text[TEXT_MAX];
    int text_len = 0;

    // Suffix array by direct comparison; matches prefix doubling, since a prefix sorts first.
    function automatic bit suffix_less(int a, int b, int n);
        int l;
        l = 0;
        while (a + l < n && b + l < n)
        begin
            if (text[a + l] != text[b + l])
                return text[a + l] < text[b + l];
            l++;
        end
        return (a + l) >= n;
    endfunction

    task automatic predict_suffix_array(int n);
        int order[TEXT_MAX];
        int t, l;
        sa_entry_t e;
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && suffix_less(order[j], order[j - 1], n); j--)
            begin
                t = order[j];
                order[j] = order[j - 1];
                order[j - 1] = t;
            end
        for (int i = 0; i < n; i++)
        begin
            l = 0;
            if (i > 0)
                while (order[i] + l < n && order[i - 1] + l < n
                       && text[order[i] + l] == text[order[i - 1] + l])
                    l++;
            e.pos = i[POS_W-1:0];
            e.start_idx = order[i][POS_W-1:0];
            e.lcp = l[LCP_W-1:0];
            e.fin = (i == n - 1);
            expected_entries.push_back(e);
        end
    endtask

    task automatic predict_byte(byte_item_t it);
        if (text_len < TEXT_MAX)
        begin
            text[text_len] = it.ch;
            text_len++;
        end
        if (it.fin)
        begin
            if (text_len > 0)
                predict_suffix_array(text_len);
            strings_built++;
            text_len = 0;
        end
    endtask

    // Set at the rising edge that accepted a transaction.
    bit accepted = 0;

    // Driver: bursts of transactions separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || accepted)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    start <= 1'b1;
                    char_in <= pending_bytes[0].ch;
                    last_char <= pending_bytes[0].fin;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Acceptance bookkeeping at the rising edge.
    always @(posedge clk)
    begin
        accepted = 0;
        if (rst_n && start && !busy)
        begin
            predict_byte(pending_bytes.pop_front());
            bytes_sent++;
            accepted = 1;
        end
    end

    // Monitor: results cannot be held off, so every strobe is checked.
    always @(posedge clk)
    begin
        sa_entry_t exp_e;
        if (rst_n && result_strobe)
        begin
            entries_seen++;
            if (expected_entries.size() == 0)
            begin
                $display("%0t: unexpected result pos=%0d start=%0d lcp=%0d last=%0b",
                         $realtime, sorted_pos, suffix_start, common_prefix, last_result);
                errors++;
            end
            else
            begin
                exp_e = expected_entries.pop_front();
                if (sorted_pos !== exp_e.pos || suffix_start !== exp_e.start_idx
                    || common_prefix !== exp_e.lcp || last_result !== exp_e.fin)
                begin
                    $display("%0t: mismatch expected pos=%0d start=%0d lcp=%0d last=%0b",
                             $realtime, exp_e.pos, exp_e.start_idx, exp_e.lcp, exp_e.fin);
                    $display("%0t:          actual pos=%0d start=%0d lcp=%0d last=%0b",
                             $realtime, sorted_pos, suffix_start, common_prefix,
                             last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_string(int n, int alphabet);
        byte_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.ch = (alphabet >= 256) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, alphabet - 1));
            it.fin = (i == n - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_fixed(byte unsigned c, int n);
        byte_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.ch = c;
            it.fin = (i == n - 1);
            pending_bytes.push_back(it);
        end
    endtask

    initial
    begin
        int n, alpha, queued;
        byte_item_t it;
        // Directed: single byte, extremes, repeats, descending bytes.
        queue_fixed(8'h00, 1);
        queue_fixed(8'hFF, 1);
        queue_fixed(8'hFF, 2);
        queue_fixed(8'h00, 5);
        it.fin = 0; it.ch = 8'hFF; pending_bytes.push_back(it);
        it.ch = 8'h80; pending_bytes.push_back(it);
        it.ch = 8'h7F; pending_bytes.push_back(it);
        it.ch = 8'h01; pending_bytes.push_back(it);
        it.ch = 8'h00; it.fin = 1; pending_bytes.push_back(it);
        // Overlong string: the bytes past the limit and the final one are dropped.
        queue_string(TEXT_MAX + 3, 4);
        queued = pending_bytes.size();
        // Random strings, mostly short, occasionally full length.
        while (queued < 430)
        begin
            if ($urandom_range(0, 9) == 0)
                n = TEXT_MAX;
            else
                n = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: alpha = 2;
                1: alpha = 4;
                2: alpha = 26;
                default: alpha = 256;
            endcase
            queue_string(n, alpha);
            queued += n;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_bytes.size() == 0);
        wait (expected_entries.size() == 0 && !busy);
        repeat (50) @(posedge clk);
        $display("Sent %0d bytes in %0d strings; checked %0d suffix array entries.",
                 bytes_sent, strings_built, entries_seen);
        if (errors == 0 && expected_entries.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
